/* src/srfe_pkg.sv */
`default_nettype none

package srfe_pkg;

    // request kinds on the input tuser
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_RECORD = 2'd2;

    // result kinds on the output tuser
    localparam logic [2:0] KIND_BYTE   = 3'd0;
    localparam logic [2:0] KIND_END    = 3'd1;
    localparam logic [2:0] KIND_ABSENT = 3'd2;
    localparam logic [2:0] KIND_ERROR  = 3'd3;
    localparam logic [2:0] KIND_DONE   = 3'd4;

    // parse phases
    localparam logic [2:0] PH_COUNT  = 3'd0;
    localparam logic [2:0] PH_ID     = 3'd1;
    localparam logic [2:0] PH_VARINT = 3'd2;
    localparam logic [2:0] PH_VALUE  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    typedef struct packed {
        logic       load_in;
        logic       tbl_write;
        logic       req_append;
        logic       count_set;
        logic       id_take;
        logic       fields_dec;
        logic       len_varint;
        logic       len_fixed;
        logic       varint_step;
        logic       value_step;
        logic       absent_step;
        logic       merge_set;
        logic       field_end;
        logic       rec_end;
        logic       phase_we;
        logic [2:0] phase_val;
        logic       emit;
        logic [2:0] emit_kind;
    } srfe_cmd_t;

    typedef struct packed {
        logic [1:0] in_type;
        logic       in_last;
        logic [2:0] phase;
        logic       load_ok;
        logic       id_ok;
        logic       count_full;
        logic       count_zero;
        logic       byte_zero;
        logic       len_zero;
        logic       varint_more;
        logic       req_more;
        logic       id_gt;
        logic       vbl_zero;
        logic       vbl_one;
        logic       copy;
        logic       fe_done;
        logic       out_free;
    } srfe_sts_t;

endpackage

`default_nettype wire

/* src/srfe_dp.sv */
`default_nettype none

module srfe_dp #(
    parameter int MAX_REQUESTS   = 16,
    parameter int FIELD_IDS      = 256,
    parameter int VALUE_LEN_BITS = 32
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire srfe_pkg::srfe_cmd_t   cmd,
    output srfe_pkg::srfe_sts_t        sts,
    input  wire [1:0]                  in_type,
    input  wire [31:0]                 in_data,
    input  wire                        in_last,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic [2:0]                 out_kind,
    output logic [3:0]                 out_slot,
    output logic [7:0]                 out_byte,
    output logic                       out_last
);

    localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int LIST_D = 1 << IDX_W;
    localparam int TBL_W  = $clog2(FIELD_IDS);
    localparam int VLB    = VALUE_LEN_BITS;

    localparam logic [4:0] SHIFT_LAST_USED = 5'd28;
    localparam logic [4:0] SHIFT_LAST_STEP = 5'd21;
    localparam logic [4:0] SHIFT_STEP      = 5'd7;
    localparam logic [4:0] SHIFT_SAT       = 5'd31;

    // latched request
    logic [1:0]  type_reg;
    logic [7:0]  id_reg;
    logic [15:0] len_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    // length table
    logic [FIELD_IDS-1:0] tbl_valid_reg;
    logic [15:0]          tbl_mem [FIELD_IDS];
    logic [15:0]          tbl_rd_reg;

    // request list
    logic [7:0]       list_mem [LIST_D];
    logic [7:0]       list_rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] idx_after;

    // parse state
    logic [2:0]     phase_reg;
    logic [7:0]     fields_reg;
    logic [7:0]     cur_reg;
    logic [VLB-1:0] vbl_reg;
    logic [VLB-1:0] vbl_next;
    logic [4:0]     shift_reg;
    logic [4:0]     shift_next;
    logic           copy_reg;

    // result register
    logic       out_valid_reg;
    logic [2:0] out_kind_reg;
    logic [3:0] out_slot_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic [38:0] varint_bits;
    logic [47:0] len_ext;
    logic        id_in_range;
    logic        load_in_range;
    logic [7:0]  slot_ext;
    logic        out_free;

    assign out_free      = !out_valid_reg || out_ready;
    assign id_in_range   = {1'b0, byte_reg} < 9'(FIELD_IDS);
    assign load_in_range = {1'b0, id_reg} < 9'(FIELD_IDS);
    assign varint_bits   = {32'd0, byte_reg[6:0]} << shift_reg;
    assign len_ext       = {32'd0, tbl_rd_reg};
    assign idx_after     = idx_reg + CNT_W'(copy_reg);
    assign slot_ext      = {{(8 - CNT_W){1'b0}}, idx_reg};

    always_comb
    begin
        sts.in_type     = type_reg;
        sts.in_last     = last_reg;
        sts.phase       = phase_reg;
        sts.load_ok     = load_in_range;
        sts.id_ok       = id_in_range && tbl_valid_reg[byte_reg[TBL_W-1:0]];
        sts.count_full  = cnt_reg >= CNT_W'(MAX_REQUESTS);
        sts.count_zero  = cnt_reg == '0;
        sts.byte_zero   = byte_reg == 8'd0;
        sts.len_zero    = tbl_rd_reg == 16'd0;
        sts.varint_more = byte_reg[7];
        sts.req_more    = idx_reg < cnt_reg;
        sts.id_gt       = cur_reg > list_rd_reg;
        sts.vbl_zero    = vbl_reg == '0;
        sts.vbl_one     = vbl_reg == VLB'(1);
        sts.copy        = copy_reg;
        sts.fe_done     = (fields_reg == 8'd0) || (idx_after >= cnt_reg);
        sts.out_free    = out_free;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.count_set || cmd.rec_end)
        begin
            idx_next = '0;
        end
        else if (cmd.absent_step || (cmd.field_end && copy_reg))
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        vbl_next   = vbl_reg;
        shift_next = shift_reg;
        if (cmd.rec_end || cmd.len_varint)
        begin
            vbl_next   = '0;
            shift_next = 5'd0;
        end
        else if (cmd.len_fixed)
        begin
            vbl_next = len_ext[VLB-1:0];
        end
        else if (cmd.varint_step)
        begin
            if (shift_reg <= SHIFT_LAST_USED)
            begin
                vbl_next = vbl_reg | varint_bits[VLB-1:0];
            end
            shift_next = (shift_reg <= SHIFT_LAST_STEP) ? shift_reg + SHIFT_STEP : SHIFT_SAT;
        end
        else if (cmd.value_step)
        begin
            vbl_next = vbl_reg - VLB'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            type_reg <= in_type;
            id_reg   <= in_data[7:0];
            len_reg  <= in_data[23:8];
            byte_reg <= in_data[31:24];
            last_reg <= in_last;
        end
    end

    // table and list storage
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_write)
        begin
            tbl_mem[id_reg[TBL_W-1:0]] <= len_reg;
        end
        tbl_rd_reg <= tbl_mem[byte_reg[TBL_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_append)
        begin
            list_mem[cnt_reg[IDX_W-1:0]] <= id_reg;
        end
        list_rd_reg <= list_mem[idx_next[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_valid_reg <= '0;
        end
        else if (cmd.tbl_write)
        begin
            tbl_valid_reg[id_reg[TBL_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            idx_reg    <= '0;
            phase_reg  <= srfe_pkg::PH_COUNT;
            fields_reg <= 8'd0;
            cur_reg    <= 8'd0;
            vbl_reg    <= '0;
            shift_reg  <= 5'd0;
            copy_reg   <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            vbl_reg   <= vbl_next;
            shift_reg <= shift_next;
            if (cmd.rec_end)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.req_append)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.rec_end)
            begin
                phase_reg <= srfe_pkg::PH_COUNT;
            end
            else if (cmd.phase_we)
            begin
                phase_reg <= cmd.phase_val;
            end
            if (cmd.rec_end)
            begin
                fields_reg <= 8'd0;
            end
            else if (cmd.count_set)
            begin
                fields_reg <= byte_reg;
            end
            else if (cmd.fields_dec)
            begin
                fields_reg <= fields_reg - 8'd1;
            end
            if (cmd.id_take)
            begin
                cur_reg <= byte_reg;
            end
            if (cmd.rec_end || cmd.count_set || cmd.field_end)
            begin
                copy_reg <= 1'b0;
            end
            else if (cmd.merge_set)
            begin
                copy_reg <= cur_reg == list_rd_reg;
            end
        end
    end

    // result register, one deep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg <= cmd.emit_kind;
            out_slot_reg <= (cmd.emit_kind == srfe_pkg::KIND_DONE) ? 4'd0 : slot_ext[3:0];
            out_byte_reg <= (cmd.emit_kind == srfe_pkg::KIND_BYTE) ? byte_reg : 8'd0;
            out_last_reg <= cmd.emit_kind == srfe_pkg::KIND_DONE;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_slot  = out_slot_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_idx_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= cnt_reg)
        else $error("request index past request count");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result issued over an untaken result");

    a_rec_end_phase: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rec_end |=> (phase_reg == srfe_pkg::PH_COUNT && cnt_reg == '0))
        else $error("record end left parse state behind");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_kind_reg == srfe_pkg::KIND_DONE)))
        else $error("tlast on a result other than record done");
`endif

endmodule

`default_nettype wire

/* src/srfe_ctrl.sv */
`default_nettype none

module srfe_ctrl (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire srfe_pkg::srfe_sts_t sts,
    output srfe_pkg::srfe_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_EXEC     = 3'd1;
    localparam logic [2:0] ST_LOOK     = 3'd2;
    localparam logic [2:0] ST_MERGE    = 3'd3;
    localparam logic [2:0] ST_FIELDEND = 3'd4;
    localparam logic [2:0] ST_FINISH   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] after_st;

    assign in_ready = state_reg == ST_IDLE;
    assign after_st = (sts.in_type == srfe_pkg::REQ_RECORD && sts.in_last) ? ST_FINISH : ST_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = after_st;
                unique case (sts.in_type)
                    srfe_pkg::REQ_LOAD:
                    begin
                        cmd.tbl_write = sts.load_ok;
                    end
                    srfe_pkg::REQ_APPEND:
                    begin
                        cmd.req_append = !sts.count_full;
                    end
                    srfe_pkg::REQ_RECORD:
                    begin
                        unique case (sts.phase)
                            srfe_pkg::PH_COUNT:
                            begin
                                cmd.count_set = 1'b1;
                                cmd.phase_we  = 1'b1;
                                cmd.phase_val = (sts.byte_zero || sts.count_zero) ?
                                                srfe_pkg::PH_DONE : srfe_pkg::PH_ID;
                            end
                            srfe_pkg::PH_ID:
                            begin
                                if (!sts.id_ok)
                                begin
                                    if (sts.out_free)
                                    begin
                                        cmd.id_take   = 1'b1;
                                        cmd.emit      = 1'b1;
                                        cmd.emit_kind = srfe_pkg::KIND_ERROR;
                                        cmd.phase_we  = 1'b1;
                                        cmd.phase_val = srfe_pkg::PH_DONE;
                                    end
                                    else
                                    begin
                                        state_next = ST_EXEC;
                                    end
                                end
                                else
                                begin
                                    cmd.id_take    = 1'b1;
                                    cmd.fields_dec = 1'b1;
                                    state_next     = ST_LOOK;
                                end
                            end
                            srfe_pkg::PH_VARINT:
                            begin
                                cmd.varint_step = 1'b1;
                                if (!sts.varint_more)
                                begin
                                    state_next = ST_MERGE;
                                end
                            end
                            srfe_pkg::PH_VALUE:
                            begin
                                if (sts.copy && !sts.out_free)
                                begin
                                    state_next = ST_EXEC;
                                end
                                else
                                begin
                                    cmd.emit       = sts.copy;
                                    cmd.emit_kind  = srfe_pkg::KIND_BYTE;
                                    cmd.value_step = 1'b1;
                                    if (sts.vbl_one)
                                    begin
                                        state_next = ST_FIELDEND;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_LOOK:
            begin
                if (sts.len_zero)
                begin
                    cmd.len_varint = 1'b1;
                    cmd.phase_we   = 1'b1;
                    cmd.phase_val  = srfe_pkg::PH_VARINT;
                    state_next     = after_st;
                end
                else
                begin
                    cmd.len_fixed = 1'b1;
                    state_next    = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (sts.req_more && sts.id_gt)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_kind   = srfe_pkg::KIND_ABSENT;
                        cmd.absent_step = 1'b1;
                    end
                end
                else if (!sts.req_more)
                begin
                    cmd.phase_we  = 1'b1;
                    cmd.phase_val = srfe_pkg::PH_DONE;
                    state_next    = after_st;
                end
                else
                begin
                    cmd.merge_set = 1'b1;
                    if (sts.vbl_zero)
                    begin
                        state_next = ST_FIELDEND;
                    end
                    else
                    begin
                        cmd.phase_we  = 1'b1;
                        cmd.phase_val = srfe_pkg::PH_VALUE;
                        state_next    = after_st;
                    end
                end
            end
            ST_FIELDEND:
            begin
                if (!sts.copy || sts.out_free)
                begin
                    cmd.emit      = sts.copy;
                    cmd.emit_kind = srfe_pkg::KIND_END;
                    cmd.field_end = 1'b1;
                    cmd.phase_we  = 1'b1;
                    cmd.phase_val = sts.fe_done ? srfe_pkg::PH_DONE : srfe_pkg::PH_ID;
                    state_next    = after_st;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = srfe_pkg::KIND_DONE;
                    cmd.rec_end   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |-> state_reg == ST_IDLE)
        else $error("request taken while busy");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rec_end |=> state_reg == ST_IDLE)
        else $error("record end did not return to idle");

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.absent_step, cmd.field_end, cmd.count_set, cmd.rec_end}))
        else $error("conflicting request index updates");
`endif

endmodule

`default_nettype wire

/* src/stored_record_field_extractor_unit.sv */
`default_nettype none

// channel   dir  tdata (low bit up)                        tuser     tlast
// s_axis    in   field_id 8, field_length 16, data_byte 8  req_type  last_byte
// m_axis    out  out_slot 4, out_byte 8, zero 4            out_kind  out_last
//
// a request is taken in idle and then executed; a known field id byte adds a look state for the length read
// a completed length adds a merge state, one step per absent marker and a field end if it is zero
// a completed value adds a field end state; the last byte of a record adds a finish state
// every result passes through a one-deep output register; a stall there holds the sequencer
// reset clears the length table valid bits, the request list count and the parser

module stored_record_field_extractor_unit #(
    parameter int MAX_REQUESTS   = 16,
    parameter int FIELD_IDS      = 256,
    parameter int VALUE_LEN_BITS = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,  // field_id, field_length, data_byte
    input  wire  [1:0]  s_axis_tuser,  // req_type
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,  // out_slot, out_byte, zero fill
    output logic [2:0]  m_axis_tuser,  // out_kind
    output logic        m_axis_tlast
);

    srfe_pkg::srfe_cmd_t cmd;
    srfe_pkg::srfe_sts_t sts;
    logic [3:0]          out_slot;
    logic [7:0]          out_byte;

    srfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    srfe_dp #(
        .MAX_REQUESTS   (MAX_REQUESTS),
        .FIELD_IDS      (FIELD_IDS),
        .VALUE_LEN_BITS (VALUE_LEN_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_type   (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_slot  (out_slot),
        .out_byte  (out_byte),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, out_byte, out_slot};

endmodule

`default_nettype wire

/* sim/stored_record_field_extractor_unit_test.sv */
`timescale 1ns / 100ps

module stored_record_field_extractor_unit_test;

    localparam logic [1:0] REQ_IGNORED = 2'd3;
    localparam int NUM_REQUESTS   = 460;
    localparam int SLOT_LIMIT     = 16;
    localparam int IDLE_LIMIT     = 3000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_RECORD_LEN = 48;
    localparam int MAX_SHOWN      = 10;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] slot;
        logic [7:0] val;
        logic       last;
    } field_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // predicted state of the extractor
    logic        len_valid [256];
    logic [15:0] len_table [256];
    logic [7:0]  wanted_ids [SLOT_LIMIT];
    int          wanted_count;
    int          slot_idx;
    logic [2:0]  phase;
    logic [7:0]  fields_left;
    logic [7:0]  cur_id;
    logic [31:0] bytes_left;
    int          vshift;
    logic        copying;
    logic        err_seen;

    field_result_t due_results[$];
    int          sent_count = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          sender_steady = 1'b0;
    int          sink_stall = 0;
    int          sink_mode_left = 0;
    bit          sink_steady = 1'b0;

    stored_record_field_extractor_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic post_result(input logic [2:0] kind, input int slot, input logic [7:0] val,
                               input logic last);
        field_result_t r;
        r.kind = kind;
        r.slot = slot[3:0];
        r.val  = val;
        r.last = last;
        due_results = {due_results, r};
    endtask

    task automatic close_field();
        if (copying)
        begin
            post_result(srfe_pkg::KIND_END, slot_idx, 8'h00, 1'b0);
            slot_idx++;
        end
        copying = 1'b0;
        phase = (fields_left == 8'd0 || slot_idx >= wanted_count) ? srfe_pkg::PH_DONE
                                                                    : srfe_pkg::PH_ID;
    endtask

    // walk the request list up to the current id
    task automatic merge_field();
        while (slot_idx < wanted_count && cur_id > wanted_ids[slot_idx])
        begin
            post_result(srfe_pkg::KIND_ABSENT, slot_idx, 8'h00, 1'b0);
            slot_idx++;
        end
        if (slot_idx >= wanted_count)
            phase = srfe_pkg::PH_DONE;
        else
        begin
            copying = (cur_id == wanted_ids[slot_idx]);
            if (bytes_left == 32'd0)
                close_field();
            else
                phase = srfe_pkg::PH_VALUE;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        case (phase)
            srfe_pkg::PH_COUNT:
            begin
                fields_left = b;
                slot_idx    = 0;
                err_seen    = 1'b0;
                copying     = 1'b0;
                phase = (b == 8'd0 || wanted_count == 0) ? srfe_pkg::PH_DONE : srfe_pkg::PH_ID;
            end
            srfe_pkg::PH_ID:
            begin
                cur_id = b;
                if (!len_valid[b])
                begin
                    post_result(srfe_pkg::KIND_ERROR, slot_idx, 8'h00, 1'b0);
                    err_seen = 1'b1;
                    phase    = srfe_pkg::PH_DONE;
                end
                else
                begin
                    fields_left = fields_left - 8'd1;
                    if (len_table[b] == 16'd0)
                    begin
                        bytes_left = 32'd0;
                        vshift     = 0;
                        phase      = srfe_pkg::PH_VARINT;
                    end
                    else
                    begin
                        bytes_left = {16'd0, len_table[b]};
                        merge_field();
                    end
                end
            end
            srfe_pkg::PH_VARINT:
            begin
                if (vshift <= 28)
                    bytes_left = bytes_left | ({25'd0, b[6:0]} << vshift);
                vshift = (vshift <= 21) ? vshift + 7 : 31;
                if (!b[7])
                    merge_field();
            end
            srfe_pkg::PH_VALUE:
            begin
                if (copying)
                    post_result(srfe_pkg::KIND_BYTE, slot_idx, b, 1'b0);
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 32'd0)
                    close_field();
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic apply_request(input logic [1:0] kind, input logic [7:0] id,
                                 input logic [15:0] len, input logic [7:0] b, input logic last);
        case (kind)
            srfe_pkg::REQ_LOAD:
            begin
                len_valid[id] = 1'b1;
                len_table[id] = len;
            end
            srfe_pkg::REQ_APPEND:
            begin
                if (wanted_count < SLOT_LIMIT)
                begin
                    wanted_ids[wanted_count] = id;
                    wanted_count++;
                end
            end
            srfe_pkg::REQ_RECORD:
            begin
                parse_byte(b);
                if (last)
                begin
                    post_result(srfe_pkg::KIND_DONE, 0, 8'h00, 1'b1);
                    wanted_count = 0;
                    slot_idx     = 0;
                    fields_left  = 8'd0;
                    bytes_left   = 32'd0;
                    vshift       = 0;
                    copying      = 1'b0;
                    phase        = srfe_pkg::PH_COUNT;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [7:0] id,
                                input logic [15:0] len, input logic [7:0] b, input logic last);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, len, id};
        s_axis_tuser  <= kind;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_request(kind, id, len, b, last);
        if (kind != REQ_IGNORED)
            sent_count++;
    endtask

    task automatic load_length(input logic [7:0] id, input logic [15:0] len);
        send_request(srfe_pkg::REQ_LOAD, id, len, 8'($urandom), 1'($urandom));
    endtask

    task automatic append_id(input logic [7:0] id);
        send_request(srfe_pkg::REQ_APPEND, id, 16'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic record_byte(input logic [7:0] b, input logic last);
        send_request(srfe_pkg::REQ_RECORD, 8'($urandom), 16'($urandom), b, last);
    endtask

    task automatic test_table_loads();
        load_length(8'd0, 16'd1);
        load_length(8'd5, 16'd0);
        load_length(8'd255, 16'hffff);
        load_length(8'd7, 16'd2);
        send_request(REQ_IGNORED, 8'hff, 16'hffff, 8'hff, 1'b1);
    endtask

    // found, absent, zero length, skipped field, long value cut short
    task automatic test_field_merge();
        append_id(8'd0);
        append_id(8'd3);
        append_id(8'd5);
        append_id(8'd255);
        record_byte(8'd4, 1'b0);
        record_byte(8'd0, 1'b0);
        record_byte(8'h00, 1'b0);
        record_byte(8'd5, 1'b0);
        record_byte(8'h00, 1'b0);
        record_byte(8'd7, 1'b0);
        record_byte(8'hff, 1'b0);
        record_byte(8'h80, 1'b0);
        record_byte(8'd255, 1'b0);
        record_byte(8'haa, 1'b1);
    endtask

    task automatic test_unknown_field();
        append_id(8'd4);
        record_byte(8'd1, 1'b0);
        record_byte(8'd4, 1'b0);
        record_byte(8'h5a, 1'b1);
    endtask

    task automatic test_empty_records();
        append_id(8'd0);
        record_byte(8'd0, 1'b1);
        record_byte(8'd2, 1'b0);
        record_byte(8'd0, 1'b0);
        record_byte(8'h11, 1'b1);
    endtask

    task automatic test_table_fill();
        int r;
        for (int i = 0; i < 32; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                load_length(8'(i), 16'd0);
            else if (r < 95)
                load_length(8'(i), 16'($urandom_range(1, 4)));
            else
                load_length(8'(i), 16'($urandom_range(5, 65535)));
        end
    endtask

    task automatic send_noise();
        int r;
        int n;
        r = $urandom_range(0, 3);
        if (r == 0)
            send_request(REQ_IGNORED, 8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
        else if (r == 1)
            load_length(8'($urandom), 16'($urandom));
        else if (r == 2)
            append_id(8'($urandom));
        else
        begin
            // broken record of random bytes
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                record_byte(8'($urandom), i == n - 1);
        end
    endtask

    task automatic send_record();
        logic [7:0] rec[$];
        int r;
        int n_req;
        int n_fld;
        int id;
        int len;
        int cut;
        r = $urandom_range(0, 99);
        if (r < 5)
            n_req = 0;
        else if (r < 85)
            n_req = $urandom_range(1, 6);
        else if (r < 95)
            n_req = $urandom_range(7, 16);
        else
            n_req = $urandom_range(17, 18);
        id = $urandom_range(0, 6);
        for (int i = 0; i < n_req; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                append_id(8'($urandom));
            else
                append_id(8'(id));
            id = id + $urandom_range(1, 2);
        end

        n_fld = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0)
            rec = {rec, 8'($urandom)};
        else
            rec = {rec, 8'(n_fld)};
        id = $urandom_range(0, 4);
        for (int f = 0; f < n_fld && rec.size() <= MAX_RECORD_LEN; f++)
        begin
            if ($urandom_range(0, 19) == 0)
                id = $urandom_range(200, 254);
            rec = {rec, 8'(id)};
            if (!len_valid[8'(id)])
            begin
                rec = {rec, 8'($urandom)};
                break;
            end
            if (len_table[8'(id)] != 16'd0)
                len = len_table[8'(id)];
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                begin
                    // over-long length prefix
                    for (int k = 0; k < 6; k++)
                        rec = {rec, 8'($urandom) | 8'h80};
                    rec = {rec, 8'($urandom) & 8'h7f};
                    len = 4;
                end
                else if (r < 10)
                begin
                    len = $urandom_range(128, 140);
                    rec = {rec, 8'(len) | 8'h80};
                    rec = {rec, 8'(len >> 7)};
                end
                else if (r < 20)
                begin
                    len = $urandom_range(0, 5);
                    rec = {rec, 8'(len) | 8'h80};
                    rec = {rec, 8'h00};
                end
                else
                begin
                    len = $urandom_range(0, 5);
                    rec = {rec, 8'(len)};
                end
            end
            for (int k = 0; k < len && rec.size() <= MAX_RECORD_LEN; k++)
                rec = {rec, 8'($urandom)};
            id = id + $urandom_range(1, 3);
        end

        while (rec.size() > MAX_RECORD_LEN)
            void'(rec.pop_back());
        if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(1, rec.size());
            while (rec.size() > cut)
                void'(rec.pop_back());
        end
        for (int i = 0; i < rec.size(); i++)
            record_byte(rec[i], i == rec.size() - 1);
    endtask

    task automatic test_random_records();
        test_table_fill();
        while (sent_count < NUM_REQUESTS)
        begin
            sender_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_record();
        end
        sender_steady = 1'b0;
    endtask

    // result sink with random stalls
    always @(posedge clk)
    begin
        if (sink_mode_left == 0)
        begin
            sink_mode_left <= $urandom_range(50, 300);
            sink_steady    <= ($urandom_range(0, 3) == 0);
        end
        else
            sink_mode_left <= sink_mode_left - 1;
        if (sink_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_stall    <= sink_stall - 1;
        end
        else if (!sink_steady && $urandom_range(0, 99) < 30)
        begin
            m_axis_tready <= 1'b0;
            sink_stall    <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                        : $urandom_range(0, 2);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        field_result_t got;
        field_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind = m_axis_tuser;
            got.slot = m_axis_tdata[3:0];
            got.val  = m_axis_tdata[11:4];
            got.last = m_axis_tlast;
            if (due_results.size() == 0)
            begin
                if (mismatches < MAX_SHOWN)
                    $display("unexpected result: kind %0d slot %0d byte %02h last %0b",
                             got.kind, got.slot, got.val, got.last);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                if (got != want || m_axis_tdata[15:12] != 4'h0)
                begin
                    if (mismatches < MAX_SHOWN)
                    begin
                        $display("mismatch: expected kind %0d slot %0d byte %02h last %0b",
                                 want.kind, want.slot, want.val, want.last);
                        $display("          got kind %0d slot %0d byte %02h last %0b fill %h",
                                 got.kind, got.slot, got.val, got.last, m_axis_tdata[15:12]);
                    end
                    mismatches++;
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            len_valid[i] = 1'b0;
            len_table[i] = 16'd0;
        end
        for (int i = 0; i < SLOT_LIMIT; i++)
            wanted_ids[i] = 8'd0;
        wanted_count = 0;
        slot_idx     = 0;
        phase        = srfe_pkg::PH_COUNT;
        fields_left  = 8'd0;
        cur_id       = 8'd0;
        bytes_left   = 32'd0;
        vshift       = 0;
        copying      = 1'b0;
        err_seen     = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_table_loads();
        test_field_merge();
        test_unknown_field();
        test_empty_records();
        test_random_records();

        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
